FILE: hw/rtl/lwbc_pkg.sv
package lwbc_pkg;

  localparam int unsigned Slots = 16;
  localparam int unsigned SlotBits = 4;
  localparam int unsigned BlockBits = 40;
  localparam int unsigned SectorBits = 52;
  localparam int unsigned SpbBits = 13;
  localparam int unsigned StampBits = 64;

  localparam logic [1:0] CmdRead = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdFlush = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] KindWriteback = 2'd0;
  localparam logic [1:0] KindFetch = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  localparam logic [SpbBits-1:0] SpbReset = 13'd8;

  typedef struct packed {
    logic [1:0]           command;
    logic [BlockBits-1:0] block_number;
    logic                 device_ok;
  } req_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SlotBits-1:0]   slot;
    logic [SectorBits-1:0] device_sector;
    logic                  hit;
    logic                  status;
    logic                  last;
  } rsp_t;

  // One slot's metadata, as stored in the slot memory. Valid bits are kept
  // in flops beside the memory.
  typedef struct packed {
    logic                 dirty;
    logic [BlockBits-1:0] tag;
    logic [StampBits-1:0] stamp;
  } meta_t;

  // Request from the controller to the sector multiplier.
  typedef struct packed {
    logic                 start;
    logic [BlockBits-1:0] block;
  } mul_req_t;

endpackage

FILE: hw/rtl/lwbc_sector_mul.sv
module lwbc_sector_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lwbc_pkg::mul_req_t                  req_i,
  input  logic [lwbc_pkg::SpbBits-1:0]        spb_i,
  output logic                                done_o,
  output logic [lwbc_pkg::SectorBits-1:0]     sector_o
);
  import lwbc_pkg::*;

  // Two partial products of 20x13 and 20x13 bits, registered and then summed.
  logic [32:0] lo_q, hi_q;
  logic        p1_q, done_q;
  logic [SectorBits-1:0] sector_q;
  logic [SectorBits-1:0] sum_d;

  // Done stays high, and the sector stays put, until the next start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      p1_q <= req_i.start;
      if (req_i.start) begin
        done_q <= 1'b0;
      end else if (p1_q) begin
        done_q <= 1'b1;
      end
    end
  end

  assign sum_d = SectorBits'({19'd0, lo_q}) + SectorBits'({hi_q, 20'd0});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      lo_q <= 33'(req_i.block[19:0]) * 33'(spb_i);
      hi_q <= 33'(req_i.block[39:20]) * 33'(spb_i);
    end
    if (p1_q) begin
      sector_q <= sum_d;
    end
  end

  assign done_o = done_q;
  assign sector_o = sector_q;

endmodule

FILE: hw/rtl/lwbc_ctrl.sv
module lwbc_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lwbc_pkg::req_t                      in_data_i,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lwbc_pkg::rsp_t                      out_data_o,
  output lwbc_pkg::mul_req_t                  mul_req_o,
  input  logic                                mul_done_i,
  input  logic [lwbc_pkg::SectorBits-1:0]     mul_sector_i
);
  import lwbc_pkg::*;

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StScan   = 11'b00000000010,
    StDecide = 11'b00000000100,
    StMul    = 11'b00000001000,
    StEmit   = 11'b00000010000,
    StWait   = 11'b00000100000,
    StUpdate = 11'b00001000000,
    StNext   = 11'b00010000000,
    StFetchM = 11'b00100000000,
    StDone   = 11'b01000000000,
    StFlushR = 11'b10000000000
  } state_e;

  // Slot metadata memory: one write and one read port, registered read.
  meta_t mem_q [Slots];
  meta_t rd_q;
  logic [SlotBits-1:0] raddr;
  logic                we;
  logic [SlotBits-1:0] waddr;
  meta_t               wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Valid bits live in flops so reset clears them at once.
  logic [Slots-1:0] valid_q, valid_d;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [SlotBits-1:0] idx_q, idx_d;     // slot whose data arrives in rd_q
  logic                rdv_q, rdv_d;     // rd_q holds data of idx_q
  logic [SlotBits:0]   scan_q, scan_d;   // next address to read
  logic                hit_q, hit_d, inv_q, inv_d;
  logic [SlotBits-1:0] hslot_q, hslot_d, vslot_q, vslot_d;
  logic [StampBits-1:0] oldest_q, oldest_d;
  logic                vdirty_q, vdirty_d;
  logic [BlockBits-1:0] vtag_q, vtag_d;
  logic [StampBits-1:0] clock_q, clock_d;
  logic                ok_q, ok_d;       // no device access of this request failed
  logic                fetch_q, fetch_d; // current multiply is the fetch
  rsp_t                out_q, out_d;
  logic                ov_q, ov_d;

  logic cur_valid;
  assign cur_valid = valid_q[idx_q];

  assign in_stall = (state_q != StIdle);
  assign out_valid = ov_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    rdv_d = 1'b0;
    scan_d = scan_q;
    hit_d = hit_q;
    inv_d = inv_q;
    hslot_d = hslot_q;
    vslot_d = vslot_q;
    oldest_d = oldest_q;
    vdirty_d = vdirty_q;
    vtag_d = vtag_q;
    clock_d = clock_q;
    ok_d = ok_q;
    fetch_d = fetch_q;
    out_d = out_q;
    ov_d = ov_q;
    valid_d = valid_q;
    raddr = scan_q[SlotBits-1:0];
    we = 1'b0;
    waddr = vslot_q;
    wdata = rd_q;
    mul_req_o.start = 1'b0;
    mul_req_o.block = req_q.block_number;
    if (ov_q && !out_stall) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        // Every sweep starts at slot 0.
        raddr = '0;
        if (in_valid) begin
          req_d = in_data_i;
          ok_d = in_data_i.device_ok;
          hit_d = 1'b0;
          inv_d = 1'b0;
          vslot_d = '0;
          oldest_d = '1;
          scan_d = (SlotBits+1)'(1);
          rdv_d = 1'b1;
          if (in_data_i.command == CmdFlush) begin
            state_d = StFlushR;
          end else if (in_data_i.command == CmdUnused) begin
            ok_d = 1'b0;
            rdv_d = 1'b0;
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rdv_q) begin
          if (cur_valid && rd_q.tag == req_q.block_number && !hit_q) begin
            hit_d = 1'b1;
            hslot_d = idx_q;
          end
          // Slot 0 is the first LRU candidate whatever its stamp.
          if (!cur_valid && !inv_q) begin
            inv_d = 1'b1;
            vslot_d = idx_q;
          end else if (!inv_q && cur_valid &&
                       (idx_q == '0 || rd_q.stamp < oldest_q)) begin
            oldest_d = rd_q.stamp;
            vslot_d = idx_q;
            vdirty_d = rd_q.dirty;
            vtag_d = rd_q.tag;
          end
        end
        if (scan_q == (SlotBits+1)'(Slots)) begin
          if (!rdv_q) state_d = StDecide;
        end else begin
          scan_d = scan_q + (SlotBits+1)'(1);
          rdv_d = 1'b1;
        end
      end
      StDecide: begin
        fetch_d = 1'b0;
        if (!hit_q && !inv_q) begin
          mul_req_o.start = vdirty_q;
          mul_req_o.block = vtag_q;
          valid_d[vslot_q] = 1'b0;
        end
        if (hit_q) begin
          scan_d = {1'b0, hslot_q};
          state_d = StWait;
        end else if (!inv_q && vdirty_q) begin
          state_d = StMul;
        end else if (req_q.command == CmdRead) begin
          state_d = StFetchM;
        end else begin
          scan_d = {1'b0, vslot_q};
          state_d = StWait;
        end
      end
      StFetchM: begin
        mul_req_o.start = 1'b1;
        fetch_d = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        if (mul_done_i && !ov_q) begin
          ov_d = 1'b1;
          out_d = '0;
          out_d.kind = fetch_q ? KindFetch : KindWriteback;
          out_d.slot = vslot_q;
          out_d.device_sector = mul_sector_i;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!ov_q || !out_stall) begin
          if (req_q.command == CmdFlush) begin
            state_d = ok_q ? StNext : StDone;
          end else if (!ok_q) begin
            // A failed writeback leaves the victim as it was.
            if (!fetch_q) valid_d[vslot_q] = 1'b1;
            state_d = StDone;
          end else if (!fetch_q && req_q.command == CmdRead) begin
            state_d = StFetchM;
          end else begin
            scan_d = {1'b0, vslot_q};
            state_d = StWait;
          end
        end
      end
      StWait: begin
        // Read the target slot so the dirty bit of a hit is kept.
        if (!rdv_q) rdv_d = 1'b1;
        else state_d = StUpdate;
      end
      StUpdate: begin
        we = 1'b1;
        wdata.tag = req_q.block_number;
        if (hit_q) begin
          waddr = hslot_q;
          wdata.dirty = rd_q.dirty | (req_q.command == CmdWrite);
        end else begin
          wdata.dirty = (req_q.command == CmdWrite);
        end
        wdata.stamp = clock_q + StampBits'(1);
        clock_d = clock_q + StampBits'(1);
        valid_d[hit_q ? hslot_q : vslot_q] = 1'b1;
        ok_d = 1'b1;
        state_d = StDone;
      end
      StFlushR: begin
        if (rdv_q) begin
          if (cur_valid && rd_q.dirty) begin
            mul_req_o.start = 1'b1;
            mul_req_o.block = rd_q.tag;
            vslot_d = idx_q;
            vtag_d = rd_q.tag;
            oldest_d = rd_q.stamp;
            fetch_d = 1'b0;
            state_d = StMul;
          end else if (scan_q == (SlotBits+1)'(Slots) &&
                       idx_q == SlotBits'(Slots-1)) begin
            ok_d = 1'b1;
            state_d = StDone;
          end else begin
            scan_d = scan_q + (SlotBits+1)'(1);
            rdv_d = (scan_q != (SlotBits+1)'(Slots));
          end
        end else if (scan_q != (SlotBits+1)'(Slots)) begin
          rdv_d = 1'b1;
          scan_d = scan_q + (SlotBits+1)'(1);
        end else begin
          ok_d = 1'b1;
          state_d = StDone;
        end
      end
      StNext: begin
        // Clear the dirty bit of the slot just written back and read the
        // following slot in the same cycle.
        we = 1'b1;
        waddr = vslot_q;
        wdata.dirty = 1'b0;
        wdata.tag = vtag_q;
        wdata.stamp = oldest_q;
        raddr = vslot_q + 1'b1;
        ok_d = 1'b1;
        if (vslot_q == SlotBits'(Slots-1)) begin
          state_d = StDone;
        end else begin
          scan_d = {1'b0, vslot_q} + (SlotBits+1)'(2);
          rdv_d = 1'b1;
          state_d = StFlushR;
        end
      end
      StDone: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          out_d = '0;
          out_d.kind = KindDone;
          out_d.last = 1'b1;
          out_d.status = !ok_q;
          if (req_q.command == CmdRead || req_q.command == CmdWrite) begin
            out_d.slot = hit_q ? hslot_q : vslot_q;
            out_d.hit = hit_q && ok_q;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    idx_d = raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      req_q <= '0;
      idx_q <= '0;
      rdv_q <= 1'b0;
      scan_q <= '0;
      hit_q <= 1'b0;
      inv_q <= 1'b0;
      hslot_q <= '0;
      vslot_q <= '0;
      oldest_q <= '0;
      vdirty_q <= 1'b0;
      vtag_q <= '0;
      clock_q <= '0;
      ok_q <= 1'b0;
      fetch_q <= 1'b0;
      out_q <= '0;
      ov_q <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      req_q <= req_d;
      idx_q <= idx_d;
      rdv_q <= rdv_d;
      scan_q <= scan_d;
      hit_q <= hit_d;
      inv_q <= inv_d;
      hslot_q <= hslot_d;
      vslot_q <= vslot_d;
      oldest_q <= oldest_d;
      vdirty_q <= vdirty_d;
      vtag_q <= vtag_d;
      clock_q <= clock_d;
      ok_q <= ok_d;
      fetch_q <= fetch_d;
      out_q <= out_d;
      ov_q <= ov_d;
      valid_q <= valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall) |=> ov_q && $stable(out_q))
    else $error("result lost under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpdate) |=> clock_q == $past(clock_q) + StampBits'(1))
    else $error("use clock not advanced");

endmodule

FILE: hw/rtl/lru_writeback_block_cache_core.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid/in_stall    lwbc_pkg::req_t
// response  out        out_valid/out_stall  lwbc_pkg::rsp_t
// config    in         cfg_we_i             sectors_per_block (13 bits)
//
// A read or write sweeps the slot memory one entry per cycle, then decides;
// it then rereads the target slot, updates it and raises the completion.
// Each writeback and each fetch adds a sector multiply and its response.
// A flush reads each slot once and adds a writeback for each dirty slot.
// Reset clears valid bits, the use clock and the register (to 8); no sweep.
// A stalled response is held until taken; the controller waits for it only
// where it has a further response to give.
module lru_writeback_block_cache_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lwbc_pkg::req_t                in_data_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lwbc_pkg::rsp_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lwbc_pkg::SpbBits-1:0]  cfg_data_i
);
  import lwbc_pkg::*;

  logic [SpbBits-1:0] spb_q;
  mul_req_t mul_req;
  logic mul_done;
  logic [SectorBits-1:0] mul_sector;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q <= SpbReset;
    end else if (cfg_we_i) begin
      spb_q <= cfg_data_i;
    end
  end

  lwbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .out_valid, .out_stall, .out_data_o,
    .mul_req_o(mul_req), .mul_done_i(mul_done), .mul_sector_i(mul_sector)
  );

  lwbc_sector_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .spb_i(spb_q),
    .done_o(mul_done), .sector_o(mul_sector)
  );

endmodule

FILE: tb/lru_writeback_block_cache_core_tb.sv
module lru_writeback_block_cache_core_tb;
  import lwbc_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  req_t in_data_i;
  logic out_valid;
  logic out_stall;
  rsp_t out_data_o;
  logic cfg_we_i;
  logic [SpbBits-1:0] cfg_data_i;

  lru_writeback_block_cache_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_i(in_data_i),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the cache directory.
  logic [BlockBits-1:0] shadow_tag [Slots];
  logic                 shadow_valid [Slots];
  logic                 shadow_dirty [Slots];
  logic [StampBits-1:0] shadow_stamp [Slots];
  logic [StampBits-1:0] shadow_clock;
  logic [SpbBits-1:0]   shadow_spb;

  rsp_t pending_rsp [$];
  int   error_count;
  int   request_count;
  int   response_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [SectorBits-1:0] sector_for(logic [BlockBits-1:0] blk);
    logic [SectorBits+SpbBits-1:0] prod;
    prod = {{(SectorBits+SpbBits-BlockBits){1'b0}}, blk} * shadow_spb;
    return prod[SectorBits-1:0];
  endfunction

  function automatic void push_rsp(logic [1:0] kind, int slot, logic [SectorBits-1:0] sec,
                                   logic hit, logic status, logic last);
    rsp_t r;
    r.kind = kind;
    r.slot = slot[SlotBits-1:0];
    r.device_sector = sec;
    r.hit = hit;
    r.status = status;
    r.last = last;
    pending_rsp.push_back(r);
  endfunction

  function automatic void mark_use(int s);
    shadow_clock = shadow_clock + 1;
    shadow_stamp[s] = shadow_clock;
  endfunction

  // Works out the responses that one request causes and updates the shadow.
  function automatic void predict_cache(req_t rq);
    int victim;
    bit failed_first;
    logic [StampBits-1:0] oldest;
    if (rq.command == CmdFlush) begin
      for (int i = 0; i < Slots; i++) begin
        if (shadow_valid[i] && shadow_dirty[i]) begin
          push_rsp(KindWriteback, i, sector_for(shadow_tag[i]), 0, 0, 0);
          if (!rq.device_ok) begin
            push_rsp(KindDone, 0, '0, 0, 1, 1);
            return;
          end
          shadow_dirty[i] = 1'b0;
        end
      end
      push_rsp(KindDone, 0, '0, 0, 0, 1);
      return;
    end
    if (rq.command == CmdUnused) begin
      push_rsp(KindDone, 0, '0, 0, 1, 1);
      return;
    end
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[i] && shadow_tag[i] == rq.block_number) begin
        if (rq.command == CmdWrite) shadow_dirty[i] = 1'b1;
        mark_use(i);
        push_rsp(KindDone, i, '0, 1, 0, 1);
        return;
      end
    end
    victim = -1;
    failed_first = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if (!shadow_valid[i] && victim < 0) victim = i;
    end
    if (victim < 0) begin
      victim = 0;
      oldest = shadow_stamp[0];
      for (int i = 1; i < Slots; i++) begin
        if (shadow_stamp[i] < oldest) begin
          oldest = shadow_stamp[i];
          victim = i;
        end
      end
      if (shadow_dirty[victim]) begin
        push_rsp(KindWriteback, victim, sector_for(shadow_tag[victim]), 0, 0, 0);
        if (!rq.device_ok) begin
          push_rsp(KindDone, victim, '0, 0, 1, 1);
          return;
        end
        failed_first = 1'b1;  // first device access already used up
      end
      shadow_valid[victim] = 1'b0;
      shadow_dirty[victim] = 1'b0;
    end
    if (rq.command == CmdRead) begin
      push_rsp(KindFetch, victim, sector_for(rq.block_number), 0, 0, 0);
      if (!failed_first && !rq.device_ok) begin
        push_rsp(KindDone, victim, '0, 0, 1, 1);
        return;
      end
      shadow_dirty[victim] = 1'b0;
    end else begin
      shadow_dirty[victim] = 1'b1;
    end
    shadow_valid[victim] = 1'b1;
    shadow_tag[victim] = rq.block_number;
    mark_use(victim);
    push_rsp(KindDone, victim, '0, 0, 0, 1);
  endfunction

  // Valid stays high after a request is taken until the next idle cycle or the
  // next request, so that it is driven only once at any edge.
  task automatic send_request(logic [1:0] cmd, logic [BlockBits-1:0] blk, logic ok);
    req_t rq;
    rq.command = cmd;
    rq.block_number = blk;
    rq.device_ok = ok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_cache(rq);
    request_count++;
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_spb(logic [SpbBits-1:0] value);
    drain_and_settle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_spb = value;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        response_count++;
        if (pending_rsp.size() == 0) begin
          $error("unexpected response kind=%0d slot=%0d", out_data_o.kind, out_data_o.slot);
          error_count++;
        end else begin
          rsp_t e;
          e = pending_rsp.pop_front();
          if (out_data_o.kind !== e.kind) begin
            $error("kind expected %0d actual %0d", e.kind, out_data_o.kind);
            error_count++;
          end
          if (out_data_o.slot !== e.slot) begin
            $error("slot expected %0d actual %0d", e.slot, out_data_o.slot);
            error_count++;
          end
          if (out_data_o.device_sector !== e.device_sector) begin
            $error("device_sector expected %0h actual %0h", e.device_sector,
                   out_data_o.device_sector);
            error_count++;
          end
          if (out_data_o.hit !== e.hit) begin
            $error("hit expected %0b actual %0b", e.hit, out_data_o.hit);
            error_count++;
          end
          if (out_data_o.status !== e.status) begin
            $error("status expected %0b actual %0b", e.status, out_data_o.status);
            error_count++;
          end
          if (out_data_o.last !== e.last) begin
            $error("last expected %0b actual %0b", e.last, out_data_o.last);
            error_count++;
          end
        end
      end
      if (hold_off) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [BlockBits-1:0] pick_block();
    // Mostly a small working set so that hits and evictions are common.
    if ($urandom_range(9) < 8) return BlockBits'($urandom_range(23));
    return BlockBits'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed();
    send_request(CmdRead, '1, 1'b1);
    send_request(CmdRead, '1, 1'b1);
    send_request(CmdWrite, '0, 1'b1);
    send_request(CmdRead, 40'h55_5555_5555, 1'b0);
    send_request(CmdWrite, 40'hAA_AAAA_AAAA, 1'b0);
    send_request(CmdFlush, '0, 1'b1);
    send_request(CmdUnused, '1, 1'b0);
    for (int i = 1; i <= 15; i++) send_request(CmdWrite, BlockBits'(i), 1'b1);
    send_request(CmdRead, 40'd100, 1'b0);  // failed fetch into a clean LRU victim
    send_request(CmdRead, 40'd101, 1'b1);
    send_request(CmdFlush, '0, 1'b0);      // flush stops at first dirty slot
  endtask

  task automatic test_config_extremes();
    write_spb(13'h1FFF);
    send_request(CmdRead, '1, 1'b1);
    send_request(CmdWrite, 40'h80_0000_0001, 1'b1);
    send_request(CmdFlush, '0, 1'b1);
    write_spb(13'd1);
    send_request(CmdRead, '1, 1'b1);
    send_request(CmdRead, 40'd7, 1'b1);
    write_spb(13'd0);
    send_request(CmdWrite, 40'd9, 1'b1);
    send_request(CmdFlush, '0, 1'b1);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    logic [1:0] cmd;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(19) == 0) ? CmdFlush : 2'($urandom_range(1));
      if ($urandom_range(39) == 0) cmd = CmdUnused;
      send_request(cmd, pick_block(), $urandom_range(5) != 0);
    end
  endtask

  task automatic test_random();
    random_phase(20, 0, 0);
    write_spb(13'($urandom_range(1, 4095)));
    random_phase(20, 83, 0);
    random_phase(20, 0, 83);
    write_spb(13'd4096);
    random_phase(20, 35, 35);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_request(2'($urandom_range(1)), pick_block(), 1'b1);
    join
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    error_count = 0;
    request_count = 0;
    response_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    shadow_clock = '0;
    shadow_spb = SpbReset;
    for (int i = 0; i < Slots; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_stamp[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    drain_and_settle();
    $display("Covered %0d requests and %0d responses over misses, hits, flushes,",
             request_count, response_count);
    $display("device failures, sector-size extremes and long output stalls.");
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("lru_writeback_block_cache_core verification clean");
    end else begin
      $display("lru_writeback_block_cache_core verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("lru_writeback_block_cache_core verification failed");
    $finish;
  end

endmodule
